### sv/itoa_pkg.sv
// Shared constants, types and the digit-to-character function for the
// integer to ASCII converter. No dependencies.
package itoa_pkg;

  // Width of the number that is converted; the input port stays 32 bits.
  localparam int VALUE_BITS  = 32;
  localparam int INPUT_BITS  = 32;
  // Most digits kept for one conversion.
  localparam int DIGIT_LIMIT = 32;
  localparam int RADIX_BITS  = 5;
  localparam int CHAR_BITS   = 7;

  localparam logic [RADIX_BITS-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_BITS-1:0] RADIX_MAX = 5'd16;
  localparam logic [RADIX_BITS-1:0] DECIMAL   = 5'd10;

  localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 7'h2D;
  localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_BITS-1:0] CHAR_ALPHA = 7'h41;
  localparam logic [CHAR_BITS-1:0] CHAR_NONE  = 7'h00;

  localparam int BIT_CNT_W = $clog2(VALUE_BITS);
  localparam int PTR_W     = $clog2(DIGIT_LIMIT);
  localparam int NDIG_W    = $clog2(DIGIT_LIMIT + 1);

  typedef logic [VALUE_BITS-1:0] mag_t;
  typedef logic [3:0]            digit_t;

  // Map one digit value 0..15 to '0'-'9' or 'A'-'F'.
  function automatic logic [CHAR_BITS-1:0] digit_char(input digit_t d);
    logic [CHAR_BITS-1:0] dx;
    dx = {3'b000, d};
    if (d < 4'd10) begin
      digit_char = CHAR_ZERO + dx;
    end else begin
      digit_char = CHAR_ALPHA + dx - 7'd10;
    end
  endfunction

endpackage

### sv/integer_to_ascii_radix.sv
// Integer to ASCII converter, radix 2 to 16, with a bit-serial divider.
// Depends on itoa_pkg.
//
// Usage: present one number on the slave stream (s_tdata carries value and
// radix, s_tuser the signed mode); a transfer happens when s_tvalid and
// s_tready are both high. The characters come out on the master stream,
// most significant digit first, one per transfer; m_tlast marks the final
// character and m_tuser flags a radix outside 2..16 (one transfer, data 0).
// The divider takes one quotient bit per cycle, and each digit runs it
// over all VALUE_BITS bits of the value.
// One number is worked on at a time; s_tready is high only while the
// converter is idle. The final character sits in the output register,
// so the next number is taken while it waits. When the receiver stalls,
// the output register holds its character and emission pauses. Reset
// clears the controller and drops any pending output.
module integer_to_ascii_radix (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [39:0] s_tdata,  // value[31:0], radix[36:32], zero pad
  input  logic       s_tuser,   // signed_mode
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // ascii_char[6:0], zero pad
  output logic       m_tlast,
  output logic       m_tuser    // bad_radix
);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_EMIT, S_BAD} state_t;

  state_t state;
  itoa_pkg::mag_t                     mag;
  logic [3:0]                         rem;
  logic [itoa_pkg::RADIX_BITS-1:0]    radix;
  logic [itoa_pkg::BIT_CNT_W-1:0]     bit_cnt;
  logic [itoa_pkg::NDIG_W-1:0]        ndig;
  logic [itoa_pkg::PTR_W-1:0]         ptr;
  logic                               neg;
  itoa_pkg::digit_t                   digits [itoa_pkg::DIGIT_LIMIT];

  // Input decode
  logic [itoa_pkg::INPUT_BITS-1:0]    in_value;
  logic [itoa_pkg::RADIX_BITS-1:0]    in_radix;
  itoa_pkg::mag_t                     in_mag;
  logic                               in_bad;
  logic                               in_neg;
  logic                               accept;

  assign in_value = s_tdata[itoa_pkg::INPUT_BITS-1:0];
  assign in_radix = s_tdata[itoa_pkg::INPUT_BITS +: itoa_pkg::RADIX_BITS];
  assign in_mag   = itoa_pkg::mag_t'(in_value);
  assign in_bad   = (in_radix < itoa_pkg::RADIX_MIN) || (in_radix > itoa_pkg::RADIX_MAX);
  assign in_neg   = s_tuser && (in_radix == itoa_pkg::DECIMAL)
                    && in_mag[itoa_pkg::VALUE_BITS-1];
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  // One restoring-division step: shift in the next dividend bit
  logic [4:0]      trial;
  logic            q_bit;
  logic [3:0]      rem_next;
  itoa_pkg::mag_t  mag_next;
  logic [4:0]      trial_diff;

  assign trial      = {rem, mag[itoa_pkg::VALUE_BITS-1]};
  assign q_bit      = (trial >= radix);
  assign trial_diff = trial - radix;
  assign rem_next   = q_bit ? trial_diff[3:0] : trial[3:0];
  assign mag_next   = {mag[itoa_pkg::VALUE_BITS-2:0], q_bit};

  // Output register may take a new character
  logic load_ok;
  assign load_ok = !m_tvalid || m_tready;

  // Output register loads a character this cycle
  logic load_char;
  assign load_char = load_ok && ((state == S_EMIT) || (state == S_BAD));

  logic last_digit;
  assign last_digit = (mag_next == '0) || (ndig == itoa_pkg::NDIG_W'(itoa_pkg::DIGIT_LIMIT - 1));

  // Controller, divider and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      neg      <= 1'b0;
      ndig     <= '0;
    end else begin
      // raise valid on a new character, drop it once the receiver takes it
      if (load_char) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            radix   <= in_radix;
            neg     <= in_neg;
            mag     <= in_neg ? (itoa_pkg::mag_t'(0) - in_mag) : in_mag;
            rem     <= '0;
            bit_cnt <= itoa_pkg::BIT_CNT_W'(itoa_pkg::VALUE_BITS - 1);
            ndig    <= '0;
            state   <= in_bad ? S_BAD : S_DIV;
          end
        end
        S_DIV: begin
          mag <= mag_next;
          if (bit_cnt == '0) begin
            // digit done: store it, stop when the quotient is exhausted or the store is full
            digits[ndig[itoa_pkg::PTR_W-1:0]] <= rem_next;
            rem     <= '0;
            bit_cnt <= itoa_pkg::BIT_CNT_W'(itoa_pkg::VALUE_BITS - 1);
            if (last_digit) begin
              ptr   <= ndig[itoa_pkg::PTR_W-1:0];
              state <= S_EMIT;
            end else begin
              ndig <= ndig + 1'b1;
            end
          end else begin
            rem     <= rem_next;
            bit_cnt <= bit_cnt - 1'b1;
          end
        end
        S_EMIT: begin
          if (load_ok) begin
            m_tuser  <= 1'b0;
            if (neg) begin
              m_tdata <= {1'b0, itoa_pkg::CHAR_MINUS};
              m_tlast <= 1'b0;
              neg     <= 1'b0;
            end else begin
              m_tdata <= {1'b0, itoa_pkg::digit_char(digits[ptr])};
              m_tlast <= (ptr == '0);
              if (ptr == '0) begin
                state <= S_IDLE;
              end else begin
                ptr <= ptr - 1'b1;
              end
            end
          end
        end
        S_BAD: begin
          if (load_ok) begin
            m_tdata  <= {1'b0, itoa_pkg::CHAR_NONE};
            m_tlast  <= 1'b1;
            m_tuser  <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A bad-radix transfer is a lone, empty, final transfer
  a_bad_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast && (m_tdata == 8'h00))
    else $error("bad radix transfer not final or not empty");

  // Every text transfer carries a non-empty character
  a_text_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> (m_tdata[6:0] != itoa_pkg::CHAR_NONE))
    else $error("text transfer with empty character");

  // Digit store never overflows while dividing
  a_ndig_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> ndig < itoa_pkg::NDIG_W'(itoa_pkg::DIGIT_LIMIT))
    else $error("digit count out of range");

  // A bad radix skips the divider
  a_bad_path: assert property (@(posedge clk) disable iff (rst)
    accept && in_bad |=> state == S_BAD)
    else $error("bad radix entered the divider");

  // The minus sign only goes out ahead of digits
  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[6:0] == itoa_pkg::CHAR_MINUS) |-> !m_tlast)
    else $error("minus sign marked as final character");

endmodule
